@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sorted table search core.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define STBS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define STBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define STBS_ASSERT_IMPLY(lbl, ante, cons)
`define STBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/stbs_pkg.sv @@
// Package for the sorted table search core: sizes, opcodes, status codes, types.
// No dependencies.
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS    = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 11;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_UNORDERED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SRCH_IDLE  = 3'b001,
        SRCH_PROBE = 3'b010,
        SRCH_HOLD  = 3'b100
    } srch_state_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [CNT_W-1:0] position;
    } srch_res_t;

endpackage

@@ hdl/stbs_key_ram.sv @@
// Key storage for the sorted table search core: one write port, one registered read port.
// Depends on stbs_pkg.
module stbs_key_ram
    import stbs_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  logic [KEY_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output logic [KEY_BITS-1:0] rdata
);

    logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/stbs_search_seq.sv @@
// Lower-bound binary search sequencer: one probe of the key RAM per cycle,
// one shared compare and bound update. Depends on stbs_pkg.
module stbs_search_seq
    import stbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] start_key,
    input  logic [CNT_W-1:0]    count,
    output logic [ADDR_W-1:0]   rd_addr,
    input  logic [KEY_BITS-1:0] rd_data,
    input  logic                take,
    output logic                busy,
    output srch_res_t           res
);

    srch_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    logic                eq_reg, eq_next;
    logic [KEY_BITS-1:0] key_reg;
    logic                lt;
    logic [CNT_W-1:0]    span;
    logic [CNT_W-1:0]    mid_wide;

    // shared compare: probed entry against the search key
    assign lt = rd_data < key_reg;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        eq_next    = eq_reg;
        case (state_reg)
            SRCH_IDLE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = count;
                    eq_next    = 1'b0;
                    state_next = SRCH_PROBE;
                end
            end
            SRCH_PROBE:
            begin
                if (lt)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                    eq_next = rd_data == key_reg;
                end
                if (!(lo_next < hi_next))
                begin
                    state_next = SRCH_HOLD;
                end
            end
            SRCH_HOLD:
            begin
                if (take)
                begin
                    state_next = SRCH_IDLE;
                end
            end
            default:
            begin
                state_next = SRCH_IDLE;
            end
        endcase
        span     = hi_next - lo_next;
        mid_wide = lo_next + (span >> 1);
        mid_next = mid_wide[ADDR_W-1:0];
    end

    // next probe address goes straight to the RAM so a probe completes each cycle
    assign rd_addr = mid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SRCH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        eq_reg  <= eq_next;
        if (start && state_reg == SRCH_IDLE)
        begin
            key_reg <= start_key;
        end
    end

    assign busy         = state_reg != SRCH_IDLE;
    assign res.valid    = state_reg == SRCH_HOLD;
    assign res.found    = eq_reg && (lo_reg < count);
    assign res.position = lo_reg;

endmodule

@@ hdl/sorted_table_binary_search_core.sv @@
// Sorted key table with lower-bound binary search lookup.
// Top level; depends on stbs_pkg, stbs_key_ram, stbs_search_seq, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, opcode, key): append, search or clear.
//   Output channel (out_valid/out_stall, found, position, status): one result
//   transaction per input transaction, in order.
// Throughput:
//   Append, clear and the unused opcode are answered without a search; the result is
//   registered and the next transaction may be accepted in the following cycle.
//   A search on a non-empty table probes one entry of the key RAM per cycle
//   (registered read port) until the bounds meet: ceil(log2(count+1)) probes,
//   at most 11 for 1024 entries, between the start step and the hand-off of
//   the result. No new transaction is taken meanwhile.
// Reset: the entry count clears to zero; the key RAM is not cleared, entries
//   at or above the count are never used in a result.
// Stall: a result waits in the output register while out_stall is high; a
//   new transaction is only taken when that register is free or being drained.
`include "assert_macros.svh"

module sorted_table_binary_search_core
    import stbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic [63:0]         key,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [POS_W-1:0]    position,
    output logic [1:0]          status
);

    logic                in_take;
    logic                out_free;
    logic [KEY_BITS-1:0] key_in;
    opcode_t             op;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [KEY_BITS-1:0] last_key_reg;

    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    position_reg, position_next;
    status_t             status_reg, status_next;
    logic                out_load;

    logic                tbl_full;
    logic                tbl_unordered;
    logic                wr_en;
    logic                srch_start;
    logic                srch_busy;
    logic                srch_take;
    logic [ADDR_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    srch_res_t           srch_res;

    assign key_in   = key[KEY_BITS-1:0];
    assign op       = opcode_t'(opcode);

    // output register is free if empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = srch_busy || !out_free;
    assign in_take  = in_valid && !in_stall;

    assign tbl_full      = count_reg == CNT_W'(TABLE_DEPTH);
    assign tbl_unordered = (count_reg != '0) && (key_in < last_key_reg);

    assign wr_en      = in_take && op == OP_APPEND && !tbl_full && !tbl_unordered;
    assign srch_start = in_take && op == OP_SEARCH && count_reg != '0;
    assign srch_take  = srch_res.valid && out_free;

    stbs_key_ram u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (key_in),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    stbs_search_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (srch_start),
        .start_key (key_in),
        .count     (count_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .take      (srch_take),
        .busy      (srch_busy),
        .res       (srch_res)
    );

    // table bookkeeping and result selection
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        status_next    = status_reg;
        out_load       = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (in_take && !srch_start)
        begin
            out_load      = 1'b1;
            found_next    = 1'b0;
            position_next = '0;
            status_next   = ST_OK;
            case (op)
                OP_APPEND:
                begin
                    position_next = POS_W'(count_reg);
                    if (tbl_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (tbl_unordered)
                    begin
                        status_next = ST_UNORDERED;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_SEARCH:
                begin
                    status_next = ST_EMPTY;
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (srch_take)
        begin
            out_load      = 1'b1;
            found_next    = srch_res.found;
            position_next = POS_W'(srch_res.position);
            status_next   = ST_OK;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        position_reg <= position_next;
        status_reg   <= status_next;
        if (wr_en)
        begin
            last_key_reg <= key_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;
    assign status    = status_reg;

    // entry count never runs past the table
    `STBS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    // a finished search never points past the end of the table
    `STBS_ASSERT_IMPLY(a_pos_bound, srch_res.valid, srch_res.position <= count_reg)
    // a hit is only reported as a normal search result inside the table
    `STBS_ASSERT_IMPLY(a_hit_ok, out_valid_reg && found_reg,
                       status_reg == ST_OK && position_reg < POS_W'(count_reg))
    // a started search keeps the input side closed on the next cycle
    `STBS_ASSERT_NEXT(a_start_busy, srch_start, srch_busy && in_stall)

endmodule
